// ----- hdl/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

    localparam int SQ_STAGES  = 16;
    localparam int SQ_STEPS   = 2;
    localparam int DIV_STAGES = 16;
    localparam int DIV_STEPS  = 2;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    localparam logic [1:0] CASE_X  = 2'd0;
    localparam logic [1:0] CASE_Y  = 2'd1;
    localparam logic [1:0] CASE_Z  = 2'd2;
    localparam logic [1:0] CASE_ID = 2'd3;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
    } mat_t;

    typedef struct packed {
        logic signed [31:0] out_w;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         branch_case;
    } quat_t;

    // Travels beside the norm through the square root and the dividers.
    typedef struct packed {
        logic [1:0]       sel;
        logic [3:0]       neg;
        logic [3:0][30:0] mag;
    } side_t;

endpackage

// ----- hdl/rmq_sqrt.sv -----
// Pipelined 64-bit integer square root, two result bits per stage.
module rmq_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [63:0]    radicand,
    input  rmq_pkg::side_t in_side,
    output logic           out_valid,
    output logic [31:0]    root,
    output rmq_pkg::side_t out_side
);
    import rmq_pkg::*;

    logic        vld_cur  [0:SQ_STAGES-1];
    logic [63:0] x_cur    [0:SQ_STAGES-1];
    logic [34:0] rem_cur  [0:SQ_STAGES-1];
    logic [31:0] root_cur [0:SQ_STAGES-1];
    side_t       side_cur [0:SQ_STAGES-1];

    logic [63:0] x_next    [0:SQ_STAGES-1];
    logic [34:0] rem_next  [0:SQ_STAGES-1];
    logic [31:0] root_next [0:SQ_STAGES-1];

    logic        vld_reg  [0:SQ_STAGES-1];
    logic [63:0] x_reg    [0:SQ_STAGES-1];
    logic [34:0] rem_reg  [0:SQ_STAGES-1];
    logic [31:0] root_reg [0:SQ_STAGES-1];
    side_t       side_reg [0:SQ_STAGES-1];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign vld_cur[s]  = in_valid;
            assign x_cur[s]    = radicand;
            assign rem_cur[s]  = '0;
            assign root_cur[s] = '0;
            assign side_cur[s] = in_side;
        end else begin : g_rest
            assign vld_cur[s]  = vld_reg[s-1];
            assign x_cur[s]    = x_reg[s-1];
            assign rem_cur[s]  = rem_reg[s-1];
            assign root_cur[s] = root_reg[s-1];
            assign side_cur[s] = side_reg[s-1];
        end

        always_comb
        begin : step
            logic [34:0] r;
            logic [31:0] q;
            logic [63:0] xx;
            logic [33:0] trial;
            r  = rem_cur[s];
            q  = root_cur[s];
            xx = x_cur[s];
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                r     = {r[32:0], xx[63:62]};
                xx    = {xx[61:0], 2'b00};
                trial = {q, 2'b01};
                if (r >= {1'b0, trial})
                begin
                    r = r - {1'b0, trial};
                    q = {q[30:0], 1'b1};
                end
                else
                begin
                    q = {q[30:0], 1'b0};
                end
            end
            rem_next[s]  = r;
            root_next[s] = q;
            x_next[s]    = xx;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_cur[s];
        end

        always_ff @(posedge clk)
        begin
            x_reg[s]    <= x_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            side_reg[s] <= side_cur[s];
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign root      = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

// ----- hdl/rmq_div.sv -----
// Four-lane pipelined restoring divider giving rounded mag * 2^30 / norm.
module rmq_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [31:0]      norm,
    input  rmq_pkg::side_t   in_side,
    output logic             out_valid,
    output logic [3:0][31:0] quot,
    output rmq_pkg::side_t   out_side
);
    import rmq_pkg::*;

    logic             vld_cur  [0:DIV_STAGES-1];
    logic [31:0]      n_cur    [0:DIV_STAGES-1];
    logic [3:0][31:0] rem_cur  [0:DIV_STAGES-1];
    logic [3:0][31:0] d_cur    [0:DIV_STAGES-1];
    logic [3:0][31:0] q_cur    [0:DIV_STAGES-1];
    side_t            side_cur [0:DIV_STAGES-1];

    logic [3:0][31:0] rem_next [0:DIV_STAGES-1];
    logic [3:0][31:0] d_next   [0:DIV_STAGES-1];
    logic [3:0][31:0] q_next   [0:DIV_STAGES-1];

    logic             vld_reg  [0:DIV_STAGES-1];
    logic [31:0]      n_reg    [0:DIV_STAGES-1];
    logic [3:0][31:0] rem_reg  [0:DIV_STAGES-1];
    logic [3:0][31:0] d_reg    [0:DIV_STAGES-1];
    logic [3:0][31:0] q_reg    [0:DIV_STAGES-1];
    side_t            side_reg [0:DIV_STAGES-1];

    logic [3:0][31:0] rem_init;
    logic [3:0][31:0] d_init;

    // Dividend is mag * 2^30 + norm / 2; the quotient fits in 32 bits, so the
    // top 30 dividend bits seed the remainder directly.
    always_comb
    begin : init
        logic [61:0] dvd;
        for (int l = 0; l < 4; l++)
        begin
            dvd         = {1'b0, in_side.mag[l], 30'd0} + {31'd0, norm[31:1]};
            rem_init[l] = {2'b00, dvd[61:32]};
            d_init[l]   = dvd[31:0];
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign vld_cur[s]  = in_valid;
            assign n_cur[s]    = norm;
            assign rem_cur[s]  = rem_init;
            assign d_cur[s]    = d_init;
            assign q_cur[s]    = '0;
            assign side_cur[s] = in_side;
        end else begin : g_rest
            assign vld_cur[s]  = vld_reg[s-1];
            assign n_cur[s]    = n_reg[s-1];
            assign rem_cur[s]  = rem_reg[s-1];
            assign d_cur[s]    = d_reg[s-1];
            assign q_cur[s]    = q_reg[s-1];
            assign side_cur[s] = side_reg[s-1];
        end

        always_comb
        begin : step
            logic [32:0] r;
            logic [31:0] dd;
            logic [31:0] qq;
            for (int l = 0; l < 4; l++)
            begin
                r  = {1'b0, rem_cur[s][l]};
                dd = d_cur[s][l];
                qq = q_cur[s][l];
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    r  = {r[31:0], dd[31]};
                    dd = {dd[30:0], 1'b0};
                    if (r >= {1'b0, n_cur[s]})
                    begin
                        r  = r - {1'b0, n_cur[s]};
                        qq = {qq[30:0], 1'b1};
                    end
                    else
                    begin
                        qq = {qq[30:0], 1'b0};
                    end
                end
                rem_next[s][l] = r[31:0];
                d_next[s][l]   = dd;
                q_next[s][l]   = qq;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_cur[s];
        end

        always_ff @(posedge clk)
        begin
            n_reg[s]    <= n_cur[s];
            rem_reg[s]  <= rem_next[s];
            d_reg[s]    <= d_next[s];
            q_reg[s]    <= q_next[s];
            side_reg[s] <= side_cur[s];
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quot      = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to unit quaternion converter, top level.
// A matrix is taken on every cycle that start is high; busy never rises.
// Each result appears with done high for one cycle, and results leave in the
// order the matrices came in. The pipeline runs through registered stages of
// sums, selection, largest magnitude, block scaling, squaring and summing, then
// 16 stages of square root and 16 stages of division at two bits per stage,
// and one output register. The receiver cannot stall the pipeline.
module rotation_matrix_to_quaternion (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rmq_pkg::mat_t matrix,
    output logic          done,
    output rmq_pkg::quat_t quat
);
    import rmq_pkg::*;

    // Stage 1: diagonal sums and off-diagonal terms.
    logic               s1_vld_reg;
    logic signed [34:0] t0_reg, t1_reg, t2_reg;
    logic signed [34:0] t0_next, t1_next, t2_next;
    logic signed [32:0] o_wx_reg, o_xy_reg, o_xz_reg, o_wy_reg, o_yz_reg, o_wz_reg;
    logic signed [32:0] o_wx_next, o_xy_next, o_xz_next, o_wy_next, o_yz_next, o_wz_next;

    assign t0_next = 35'($signed(ONE_Q30)) + 35'(matrix.r00) - 35'(matrix.r11)
                     - 35'(matrix.r22);
    assign t1_next = 35'($signed(ONE_Q30)) - 35'(matrix.r00) + 35'(matrix.r11)
                     - 35'(matrix.r22);
    assign t2_next = 35'($signed(ONE_Q30)) - 35'(matrix.r00) - 35'(matrix.r11)
                     + 35'(matrix.r22);
    assign o_wx_next = 33'(matrix.r21) - 33'(matrix.r12);
    assign o_xy_next = 33'(matrix.r01) + 33'(matrix.r10);
    assign o_xz_next = 33'(matrix.r02) + 33'(matrix.r20);
    assign o_wy_next = 33'(matrix.r02) - 33'(matrix.r20);
    assign o_yz_next = 33'(matrix.r12) + 33'(matrix.r21);
    assign o_wz_next = 33'(matrix.r10) - 33'(matrix.r01);

    // Stage 2: pick the dominant axis and split the vector into sign and size.
    logic             s2_vld_reg;
    logic [1:0]       s2_sel_reg, s2_sel_next;
    logic [3:0]       s2_neg_reg, s2_neg_next;
    logic [3:0][33:0] s2_mag_reg, s2_mag_next;

    always_comb
    begin : pick
        logic signed [34:0] v [0:3];
        if (t0_reg > t1_reg && t0_reg > t2_reg && t0_reg > 35'sd0)
        begin
            s2_sel_next = CASE_X;
            v[0] = 35'(o_wx_reg); v[1] = t0_reg;
            v[2] = 35'(o_xy_reg); v[3] = 35'(o_xz_reg);
        end
        else if (t1_reg > t0_reg && t1_reg > t2_reg && t1_reg > 35'sd0)
        begin
            s2_sel_next = CASE_Y;
            v[0] = 35'(o_wy_reg); v[1] = 35'(o_xy_reg);
            v[2] = t1_reg;        v[3] = 35'(o_yz_reg);
        end
        else if (t2_reg > t0_reg && t2_reg > t1_reg && t2_reg > 35'sd0)
        begin
            s2_sel_next = CASE_Z;
            v[0] = 35'(o_wz_reg); v[1] = 35'(o_xz_reg);
            v[2] = 35'(o_yz_reg); v[3] = t2_reg;
        end
        else
        begin
            s2_sel_next = CASE_ID;
            v[0] = 35'sd0; v[1] = 35'sd0; v[2] = 35'sd0; v[3] = 35'sd0;
        end
        for (int i = 0; i < 4; i++)
        begin
            s2_neg_next[i] = v[i][34];
            s2_mag_next[i] = v[i][34] ? 34'(-v[i]) : v[i][33:0];
        end
    end

    // Stage 3: largest magnitude.
    logic             s3_vld_reg;
    logic [1:0]       s3_sel_reg;
    logic [3:0]       s3_neg_reg;
    logic [3:0][33:0] s3_mag_reg;
    logic [33:0]      s3_mx_reg, s3_mx_next;

    always_comb
    begin : largest
        logic [33:0] a, b;
        a = (s2_mag_reg[0] > s2_mag_reg[1]) ? s2_mag_reg[0] : s2_mag_reg[1];
        b = (s2_mag_reg[2] > s2_mag_reg[3]) ? s2_mag_reg[2] : s2_mag_reg[3];
        s3_mx_next = (a > b) ? a : b;
    end

    // Stage 4: shift all four together so the largest lands in [2^30, 2^31).
    logic             s4_vld_reg;
    side_t            s4_side_reg, s4_side_next;

    always_comb
    begin : scale
        logic [5:0] msb;
        msb = 6'd30;
        for (int b = 0; b < 34; b++)
        begin
            if (s3_mx_reg[b])
                msb = 6'(b);
        end
        s4_side_next.sel = s3_sel_reg;
        s4_side_next.neg = s3_neg_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (msb >= 6'd30)
                s4_side_next.mag[i] = 31'(s3_mag_reg[i] >> (msb - 6'd30));
            else
                s4_side_next.mag[i] = 31'(s3_mag_reg[i] << (6'd30 - msb));
        end
    end

    // Stage 5: squares.
    logic             s5_vld_reg;
    side_t            s5_side_reg;
    logic [3:0][61:0] s5_sq_reg, s5_sq_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s5_sq_next[i] = 62'(s4_side_reg.mag[i]) * 62'(s4_side_reg.mag[i]);
    end

    // Stage 6: sum of squares.
    logic        s6_vld_reg;
    side_t       s6_side_reg;
    logic [63:0] s6_sum_reg, s6_sum_next;

    assign s6_sum_next = 64'(s5_sq_reg[0]) + 64'(s5_sq_reg[1]) + 64'(s5_sq_reg[2])
                         + 64'(s5_sq_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start & ~busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        o_wx_reg    <= o_wx_next;
        o_xy_reg    <= o_xy_next;
        o_xz_reg    <= o_xz_next;
        o_wy_reg    <= o_wy_next;
        o_yz_reg    <= o_yz_next;
        o_wz_reg    <= o_wz_next;
        s2_sel_reg  <= s2_sel_next;
        s2_neg_reg  <= s2_neg_next;
        s2_mag_reg  <= s2_mag_next;
        s3_sel_reg  <= s2_sel_reg;
        s3_neg_reg  <= s2_neg_reg;
        s3_mag_reg  <= s2_mag_reg;
        s3_mx_reg   <= s3_mx_next;
        s4_side_reg <= s4_side_next;
        s5_side_reg <= s4_side_reg;
        s5_sq_reg   <= s5_sq_next;
        s6_side_reg <= s5_side_reg;
        s6_sum_reg  <= s6_sum_next;
    end

    logic        sq_vld;
    logic [31:0] sq_root;
    side_t       sq_side;

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_vld_reg),
        .radicand  (s6_sum_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    logic             dv_vld;
    logic [3:0][31:0] dv_quot;
    side_t            dv_side;

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .norm      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_vld),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    // Output register: apply signs, or the identity when no axis dominates.
    logic  done_reg;
    quat_t quat_reg, quat_next;

    always_comb
    begin : finish
        logic [3:0][31:0] r;
        for (int i = 0; i < 4; i++)
            r[i] = dv_side.neg[i] ? (32'd0 - dv_quot[i]) : dv_quot[i];
        if (dv_side.sel == CASE_ID)
        begin
            quat_next.out_w = $signed(ONE_Q30);
            quat_next.out_x = '0;
            quat_next.out_y = '0;
            quat_next.out_z = '0;
        end
        else
        begin
            quat_next.out_w = $signed(r[0]);
            quat_next.out_x = $signed(r[1]);
            quat_next.out_y = $signed(r[2]);
            quat_next.out_z = $signed(r[3]);
        end
        quat_next.branch_case = dv_side.sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign quat = quat_reg;

endmodule

// ----- test/rotation_matrix_to_quaternion_test.sv -----
// Testbench for the rotation matrix to quaternion converter: directed table plus random matrices.
module rotation_matrix_to_quaternion_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int LATENCY = 39;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_COUNT = 750;
    localparam logic signed [31:0] P1 = 32'sh4000_0000;
    localparam logic signed [31:0] M1 = -32'sh4000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    mat_t matrix = '0;
    quat_t quat;

    quat_t quat_pending[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    typedef struct {
        mat_t m;
        bit known;
        quat_t q;
    } row_t;
    row_t rows[$];

    rotation_matrix_to_quaternion dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .matrix(matrix), .done(done), .quat(quat)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic quat_t matrix_to_quat(mat_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, t0, t1, t2;
        longint v[4];
        longint unsigned mag[4];
        longint unsigned big, n, q;
        bit neg[4];
        logic [1:0] sel;
        quat_t r;
        a00 = m.r00; a01 = m.r01; a02 = m.r02;
        a10 = m.r10; a11 = m.r11; a12 = m.r12;
        a20 = m.r20; a21 = m.r21; a22 = m.r22;
        t0 = 64'sd1073741824 + a00 - a11 - a22;
        t1 = 64'sd1073741824 - a00 + a11 - a22;
        t2 = 64'sd1073741824 - a00 - a11 + a22;
        r = '0;
        r.out_w = P1;
        r.branch_case = CASE_ID;
        if (t0 > t1 && t0 > t2 && t0 > 0)
        begin
            sel = CASE_X;
            v[0] = a21 - a12; v[1] = t0; v[2] = a01 + a10; v[3] = a02 + a20;
        end
        else if (t1 > t0 && t1 > t2 && t1 > 0)
        begin
            sel = CASE_Y;
            v[0] = a02 - a20; v[1] = a01 + a10; v[2] = t1; v[3] = a12 + a21;
        end
        else if (t2 > t0 && t2 > t1 && t2 > 0)
        begin
            sel = CASE_Z;
            v[0] = a10 - a01; v[1] = a02 + a20; v[2] = a12 + a21; v[3] = t2;
        end
        else
            return r;
        big = 0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > big) big = mag[i];
        end
        while (big >= (64'd1 << 31))
        begin
            big >>= 1;
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end
        while (big < (64'd1 << 30))
        begin
            big <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        n = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2] + mag[3] * mag[3]);
        for (int i = 0; i < 4; i++)
        begin
            q = ((mag[i] << 30) + (n >> 1)) / n;
            v[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        r.out_w = v[0][31:0];
        r.out_x = v[1][31:0];
        r.out_y = v[2][31:0];
        r.out_z = v[3][31:0];
        r.branch_case = sel;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_entry();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            return $urandom_range(0, 1) ? P1 : M1;
        return $signed($urandom_range(0, 32'h8000_0000)) - P1;
    endfunction

    // A proper rotation built from a random unit quaternion, truncated toward zero to Q2.30.
    function automatic mat_t rand_rotation();
        real a, b, c, d, s;
        real e[9];
        mat_t m;
        a = $urandom_range(0, 20000) / 10000.0 - 1.0;
        b = $urandom_range(0, 20000) / 10000.0 - 1.0;
        c = $urandom_range(0, 20000) / 10000.0 - 1.0;
        d = $urandom_range(0, 20000) / 10000.0 - 1.0;
        s = $sqrt(a * a + b * b + c * c + d * d);
        if (s < 0.001)
        begin
            a = 1.0;
            s = 1.0;
        end
        a /= s; b /= s; c /= s; d /= s;
        e[0] = 1 - 2 * (c * c + d * d); e[1] = 2 * (b * c - a * d); e[2] = 2 * (b * d + a * c);
        e[3] = 2 * (b * c + a * d); e[4] = 1 - 2 * (b * b + d * d); e[5] = 2 * (c * d - a * b);
        e[6] = 2 * (b * d - a * c); e[7] = 2 * (c * d + a * b); e[8] = 1 - 2 * (b * b + c * c);
        for (int i = 0; i < 9; i++)
        begin
            if (e[i] > 1.0) e[i] = 1.0;
            if (e[i] < -1.0) e[i] = -1.0;
        end
        m.r00 = $rtoi(e[0] * 1073741824.0); m.r01 = $rtoi(e[1] * 1073741824.0);
        m.r02 = $rtoi(e[2] * 1073741824.0); m.r10 = $rtoi(e[3] * 1073741824.0);
        m.r11 = $rtoi(e[4] * 1073741824.0); m.r12 = $rtoi(e[5] * 1073741824.0);
        m.r20 = $rtoi(e[6] * 1073741824.0); m.r21 = $rtoi(e[7] * 1073741824.0);
        m.r22 = $rtoi(e[8] * 1073741824.0);
        return m;
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        m = rand_rotation();
        if ($urandom_range(0, 3) == 0)
            m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                 rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        else if ($urandom_range(0, 3) == 0)
            m.r01 = rand_entry();
        return m;
    endfunction

    function automatic void add_row(mat_t m, bit known, quat_t q);
        row_t r;
        r.m = m;
        r.known = known;
        r.q = q;
        rows = {rows, r};
    endfunction

    // Hold the matrix on the port until a beat is taken.
    task automatic send(mat_t m, quat_t q, bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        matrix <= m;
        @(posedge clk);
        while (busy) @(posedge clk);
        quat_pending = {quat_pending, q};
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (quat_pending.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %h", quat);
                end
                else if (quat !== quat_pending[0])
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("quat mismatch: exp w=%h x=%h y=%h z=%h c=%0d",
                            quat_pending[0].out_w, quat_pending[0].out_x,
                            quat_pending[0].out_y, quat_pending[0].out_z,
                            quat_pending[0].branch_case);
                        $display("               got w=%h x=%h y=%h z=%h c=%0d",
                            quat.out_w, quat.out_x, quat.out_y, quat.out_z,
                            quat.branch_case);
                    end
                    void'(quat_pending.pop_front());
                end
                else
                    void'(quat_pending.pop_front());
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
                $display("rotation_matrix_to_quaternion_test: errors");
                $finish;
            end
        end
    end

    initial
    begin
        quat_t ident;
        quat_t x_pos;
        quat_t none;
        mat_t m;
        int n;
        ident = '{out_w: P1, out_x: 0, out_y: 0, out_z: 0, branch_case: CASE_ID};
        x_pos = '{out_w: 0, out_x: P1, out_y: 0, out_z: 0, branch_case: CASE_X};
        none = '0;
        // Identity matrix: all three sums tie.
        add_row('{P1, 0, 0, 0, P1, 0, 0, 0, P1}, 1'b1, ident);
        add_row('0, 1'b1, ident);
        // 180 degrees about x: x dominant, pure x component.
        add_row('{P1, 0, 0, 0, M1, 0, 0, 0, M1}, 1'b1, x_pos);
        add_row('{M1, 0, 0, 0, P1, 0, 0, 0, M1}, 1'b0, none);
        add_row('{M1, 0, 0, 0, M1, 0, 0, 0, P1}, 1'b0, none);
        // Dominant sum not positive needs entries outside the unit range.
        add_row('{M1, 0, 0, 0, M1, 0, 0, 0, 32'sh7fff_ffff}, 1'b0, none);
        add_row('{32'sh8000_0000, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff},
            1'b1, ident);
        add_row('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
            32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
            32'sh8000_0000}, 1'b0, none);
        add_row('{M1, P1, M1, P1, M1, P1, M1, P1, M1}, 1'b0, none);
        add_row('{0, M1, 0, P1, 0, 0, 0, 0, P1}, 1'b0, none);
        add_row('{0, 0, P1, 0, P1, 0, M1, 0, 0}, 1'b0, none);
        add_row('{P1, 0, 0, 0, 0, M1, 0, P1, 0}, 1'b0, none);
        add_row('{P1, 1, 0, 0, P1, 0, 0, 0, P1 - 1}, 1'b0, none);
        add_row('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
            32'sh7fff_ffff}, 1'b0, none);
        add_row('{-1, -1, -1, -1, 0, -1, -1, -1, -1}, 1'b0, none);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (rows[i])
            send(rows[i].m, rows[i].known ? rows[i].q : matrix_to_quat(rows[i].m), 1'b0);
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            m = rand_matrix();
            send(m, matrix_to_quat(m), i < RANDOM_COUNT - 100);
        end
        start <= 1'b0;
        n = 0;
        while (quat_pending.size() != 0 && n < 10 * LATENCY)
        begin
            @(posedge clk);
            n++;
        end
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0 && quat_pending.size() == 0 && !timed_out)
            $display("rotation_matrix_to_quaternion_test: clean");
        else
            $display("rotation_matrix_to_quaternion_test: errors");
        $finish;
    end
endmodule
